### hw/rtl/crsp_pkg.sv
// crsp_pkg: shared types and constants of the Catmull-Rom spline point block
// request and result structs, coordinate and lane control types
// no dependencies
package crsp_pkg;

    // fixed field widths
    localparam int COORD_BITS = 32;
    localparam int SLOT_BITS  = 6;
    localparam int BLEND_BITS = 16;
    localparam int COUNT_BITS = 7;

    // smallest usable point count and reset value of the count register
    localparam int                    MIN_POINTS  = 4;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd4;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // accumulator width of the polynomial datapath
    localparam int ACC_BITS = COORD_BITS + 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;

    typedef struct packed {
        logic                  cmd;
        logic [SLOT_BITS-1:0]  slot;
        coord_t                coord_x;
        coord_t                coord_y;
        coord_t                coord_z;
        logic [BLEND_BITS-1:0] blend;
    } request_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
    } result_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // per-item control that travels with one coordinate lane
    typedef struct packed {
        logic                  pass;
        logic [BLEND_BITS-1:0] blend;
    } lane_ctrl_t;

endpackage

### hw/rtl/crsp_lane.sv
// crsp_lane: one coordinate of the spline evaluation, five register stages
// coefficients, three multiply-accumulate steps, halving and saturation
// depends on crsp_pkg
module crsp_lane
    import crsp_pkg::*;
(
    input  logic       clk,
    input  lane_ctrl_t ctrl,
    input  coord_t     p0,
    input  coord_t     p1,
    input  coord_t     p2,
    input  coord_t     p3,
    output coord_t     pos
);

    localparam int PROD_BITS = ACC_BITS + BLEND_BITS + 1;

    acc_t e0, e1, e2, e3;
    acc_t ca_next, cb_next, cc_next, cd_next;
    acc_t ca_reg, cb_reg, cc_reg, cd_reg;
    acc_t ca3_reg, cb3_reg, ca4_reg;
    acc_t acc1_reg, acc2_reg, acc3_reg;
    acc_t acc1_next, acc2_next, acc3_next;
    acc_t half;
    logic [BLEND_BITS-1:0] t2_reg, t3_reg, t4_reg;
    logic signed [BLEND_BITS:0] t2_s, t3_s, t4_s;
    logic signed [PROD_BITS-1:0] mac1, mac2, mac3;
    coord_t pos_next, pos_reg;
    logic sat_hi, sat_lo;

    // widen control points
    assign e0 = ACC_BITS'(p0);
    assign e1 = ACC_BITS'(p1);
    assign e2 = ACC_BITS'(p2);
    assign e3 = ACC_BITS'(p3);

    // polynomial coefficients; an end point request keeps only 2*p1
    always_comb
    begin
        ca_next = e1 <<< 1;
        if (ctrl.pass)
        begin
            cb_next = '0;
            cc_next = '0;
            cd_next = '0;
        end
        else
        begin
            cb_next = e2 - e0;
            cc_next = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
            cd_next = e3 - e0 + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2);
        end
    end

    // signed views of t
    assign t2_s = $signed({1'b0, t2_reg});
    assign t3_s = $signed({1'b0, t3_reg});
    assign t4_s = $signed({1'b0, t4_reg});

    // horner steps: floor(a*t/2^16) + c as one multiply-accumulate
    assign mac1 = cd_reg * t2_s + (PROD_BITS'(cc_reg) <<< BLEND_BITS);
    assign mac2 = acc1_reg * t3_s + (PROD_BITS'(cb3_reg) <<< BLEND_BITS);
    assign mac3 = acc2_reg * t4_s + (PROD_BITS'(ca4_reg) <<< BLEND_BITS);
    assign acc1_next = mac1[ACC_BITS+BLEND_BITS-1:BLEND_BITS];
    assign acc2_next = mac2[ACC_BITS+BLEND_BITS-1:BLEND_BITS];
    assign acc3_next = mac3[ACC_BITS+BLEND_BITS-1:BLEND_BITS];

    // halve toward minus infinity, then saturate
    assign half   = acc3_reg >>> 1;
    assign sat_hi = !half[ACC_BITS-1] && (half[ACC_BITS-2:COORD_BITS-1] != '0);
    assign sat_lo = half[ACC_BITS-1] && (half[ACC_BITS-2:COORD_BITS-1] != '1);

    always_comb
    begin
        if (sat_hi)
        begin
            pos_next = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        else if (sat_lo)
        begin
            pos_next = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            pos_next = half[COORD_BITS-1:0];
        end
    end

    // pipeline registers, payload only
    always_ff @(posedge clk)
    begin
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        cc_reg   <= cc_next;
        cd_reg   <= cd_next;
        t2_reg   <= ctrl.blend;
        acc1_reg <= acc1_next;
        cb3_reg  <= cb_reg;
        ca3_reg  <= ca_reg;
        t3_reg   <= t2_reg;
        acc2_reg <= acc2_next;
        ca4_reg  <= ca3_reg;
        t4_reg   <= t3_reg;
        acc3_reg <= acc3_next;
        pos_reg  <= pos_next;
    end

    assign pos = pos_reg;

endmodule

### hw/rtl/catmull_rom_spline_point_top.sv
// catmull_rom_spline_point_top: control point table and spline point pipeline
// holds the point memories, count register, index logic and three lanes
// depends on crsp_pkg and crsp_lane
//
// path: an evaluate request passes the registered table read, the coefficients, three
// multiply-accumulates and the output register before its result strobe
// throughput: one request per cycle, busy stays low; write requests give no result
// reset: clears the count register to 4 and the stage valid bits; the point
// table holds no reset value and must be written before it is read
module catmull_rom_spline_point_top
    import crsp_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  request_t              req,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,
    output logic                  done,
    output result_t               result
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = ((CW > COUNT_BITS) ? CW : COUNT_BITS) + 1;
    localparam int LAT = 6;

    logic [COUNT_BITS-1:0] point_count_reg;
    logic [LAT-1:0] valid_reg, valid_next;
    logic accept, wr_accept, eval_accept;
    logic [IW-1:0] pc, cnt, n, slot_w, i3, e;
    logic [IW-1:0] a0, a1, a2, a3;
    logic hi, lo, pass;
    lane_ctrl_t ctrl_reg;
    point_t wr_point;
    point_t rd0_reg, rd1_reg, rd2_reg, rd3_reg;
    point_t mem_a [MAX_POINTS];
    point_t mem_b [MAX_POINTS];

    // request handshake, never stalls
    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign slot_w      = IW'(req.slot);
    assign wr_accept   = accept && (req.cmd == CMD_WRITE) && (slot_w < IW'(MAX_POINTS));
    assign eval_accept = accept && (req.cmd == CMD_EVAL);

    // clamp the point count into the usable range
    assign pc  = IW'(point_count_reg);
    assign cnt = (pc < IW'(MIN_POINTS)) ? IW'(MIN_POINTS) :
                 ((pc > IW'(MAX_POINTS)) ? IW'(MAX_POINTS) : pc);
    assign n   = cnt - IW'(2);

    // segment indices, end point selection outside the valid segments
    assign hi   = slot_w > n;
    assign lo   = slot_w == '0;
    assign pass = hi || lo;
    assign e    = hi ? n : IW'(1);
    assign i3   = ((slot_w + IW'(2)) > (cnt - IW'(1))) ? (cnt - IW'(1)) : (slot_w + IW'(2));
    assign a0   = slot_w - IW'(1);
    assign a1   = pass ? e : slot_w;
    assign a2   = slot_w + IW'(1);
    assign a3   = i3;

    assign wr_point = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};

    // two copies of the table, two read ports each
    always_ff @(posedge clk)
    begin
        if (wr_accept)
        begin
            mem_a[slot_w[AW-1:0]] <= wr_point;
            mem_b[slot_w[AW-1:0]] <= wr_point;
        end
        rd0_reg  <= mem_a[a0[AW-1:0]];
        rd1_reg  <= mem_a[a1[AW-1:0]];
        rd2_reg  <= mem_b[a2[AW-1:0]];
        rd3_reg  <= mem_b[a3[AW-1:0]];
        ctrl_reg <= '{pass: pass, blend: req.blend};
    end

    // valid bits per stage
    assign valid_next = {valid_reg[LAT-2:0], eval_accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            point_count_reg <= COUNT_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr_en)
            begin
                point_count_reg <= cfg_wr_data;
            end
        end
    end

    // coordinate lanes
    crsp_lane u_lane_x (
        .clk  (clk),
        .ctrl (ctrl_reg),
        .p0   (rd0_reg.x),
        .p1   (rd1_reg.x),
        .p2   (rd2_reg.x),
        .p3   (rd3_reg.x),
        .pos  (result.pos_x)
    );

    crsp_lane u_lane_y (
        .clk  (clk),
        .ctrl (ctrl_reg),
        .p0   (rd0_reg.y),
        .p1   (rd1_reg.y),
        .p2   (rd2_reg.y),
        .p3   (rd3_reg.y),
        .pos  (result.pos_y)
    );

    crsp_lane u_lane_z (
        .clk  (clk),
        .ctrl (ctrl_reg),
        .p0   (rd0_reg.z),
        .p1   (rd1_reg.z),
        .p2   (rd2_reg.z),
        .p3   (rd3_reg.z),
        .pos  (result.pos_z)
    );

    assign done = valid_reg[LAT-1];

    // an evaluate request yields a strobe after the pipeline latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd == CMD_EVAL) |-> ##6 done)
        else $error("evaluate request lost its result");

    // a write request never yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd == CMD_WRITE) |-> ##6 !done)
        else $error("write request produced a result");

    // the count register changes only on a configuration write
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr_en |=> $stable(point_count_reg))
        else $error("point count changed without a write");

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench of the catmull-rom spline point block
// drives write and evaluate requests, predicts each spline point, checks results
// depends on crsp_pkg and catmull_rom_spline_point_top
module tb_top
    import crsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 64;
    localparam int DRAIN_CYCLES = 10;
    localparam int QUIET_LIMIT  = 400;
    localparam int PHASE_ITEMS  = 150;
    localparam int MAX_REPORTS  = 10;

    // tracks the point table and count, holds the points still to come back
    class spline_tracker;
        longint  pts [TABLE_DEPTH][3];
        int      point_cnt;
        result_t pending_points [$];
        int      mismatches;

        function new();
            point_cnt  = MIN_POINTS;
            mismatches = 0;
            foreach (pts[i, k])
                pts[i][k] = 0;
        endfunction

        function void set_count(logic [COUNT_BITS-1:0] v);
            point_cnt = v;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        // one axis of the cubic by horner's rule, floor at each step
        function longint eval_axis(longint p0, longint p1, longint p2, longint p3,
                                   longint t);
            longint acc;
            acc = -p0 + 3 * p1 - 3 * p2 + p3;
            acc = ((acc * t) >>> 16) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
            acc = ((acc * t) >>> 16) + (p2 - p0);
            acc = ((acc * t) >>> 16) + 2 * p1;
            return acc >>> 1;
        endfunction

        function coord_t clip(longint v);
            if (v > 64'sh7FFF_FFFF)
                return coord_t'(32'h7FFF_FFFF);
            if (v < -64'sh8000_0000)
                return coord_t'(32'h8000_0000);
            return coord_t'(v);
        endfunction

        // accepted request: update the table or queue the expected point
        function void note_request(request_t r);
            int     cnt;
            int     last_seg;
            int     s;
            int     i3;
            longint t;
            coord_t v [3];
            s = r.slot;
            if (r.cmd == CMD_WRITE)
            begin
                pts[s][0] = longint'(r.coord_x);
                pts[s][1] = longint'(r.coord_y);
                pts[s][2] = longint'(r.coord_z);
                return;
            end
            cnt = point_cnt;
            if (cnt < MIN_POINTS)
                cnt = MIN_POINTS;
            if (cnt > TABLE_DEPTH)
                cnt = TABLE_DEPTH;
            last_seg = cnt - 2;
            t = longint'(r.blend);
            if (s > last_seg || s < 1)
            begin
                // outside the segments: end point unchanged
                s = (s > last_seg) ? last_seg : 1;
                for (int k = 0; k < 3; k++)
                    v[k] = clip(pts[s][k]);
            end
            else
            begin
                // last segment repeats the final point
                i3 = (s + 2 > cnt - 1) ? cnt - 1 : s + 2;
                for (int k = 0; k < 3; k++)
                    v[k] = clip(eval_axis(pts[s-1][k], pts[s][k], pts[s+1][k],
                                          pts[i3][k], t));
            end
            pending_points.push_back('{pos_x: v[0], pos_y: v[1], pos_z: v[2]});
        endfunction

        function void report(string what, result_t exp_pt, result_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s: exp x=%h y=%h z=%h got x=%h y=%h z=%h", what,
                         exp_pt.pos_x, exp_pt.pos_y, exp_pt.pos_z,
                         got.pos_x, got.pos_y, got.pos_z);
        endfunction

        // compare one result with the oldest expected point
        function void check_point(result_t got);
            result_t exp_pt;
            if (pending_points.size() == 0)
            begin
                report("result with no request waiting", '0, got);
                return;
            end
            exp_pt = pending_points.pop_front();
            if (got.pos_x !== exp_pt.pos_x || got.pos_y !== exp_pt.pos_y ||
                got.pos_z !== exp_pt.pos_z)
                report("point mismatch", exp_pt, got);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    request_t              req         = '0;
    logic                  cfg_wr_en   = 1'b0;
    logic [COUNT_BITS-1:0] cfg_wr_data = '0;
    logic                  done;
    result_t               result;

    spline_tracker tracker;
    bit            loaded [TABLE_DEPTH];
    int            quiet;

    catmull_rom_spline_point_top #(
        .MAX_POINTS (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result sampling
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_point(result);
    end

    // watchdog on cycles with no request or result
    initial
    begin : watchdog
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // random coordinate: extremes, small values near zero, or anything
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0:       return coord_t'(32'h7FFF_FFFF);
            1:       return coord_t'(32'h8000_0000);
            2, 3:    return coord_t'($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic logic [BLEND_BITS-1:0] rand_blend();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BLEND_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic request_t write_req(int s, coord_t x, coord_t y, coord_t z);
        request_t r;
        r.cmd     = CMD_WRITE;
        r.slot    = SLOT_BITS'(s);
        r.coord_x = x;
        r.coord_y = y;
        r.coord_z = z;
        r.blend   = rand_blend();
        return r;
    endfunction

    // evaluate request, coordinate fields carry noise
    function automatic request_t eval_req(int s, logic [BLEND_BITS-1:0] t);
        request_t r;
        r.cmd     = CMD_EVAL;
        r.slot    = SLOT_BITS'(s);
        r.coord_x = coord_t'($urandom());
        r.coord_y = coord_t'($urandom());
        r.coord_z = coord_t'($urandom());
        r.blend   = t;
        return r;
    endfunction

    // hold start high until the request is taken
    task automatic send_request(request_t r);
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_request(r);
        if (r.cmd == CMD_WRITE)
            loaded[r.slot] = 1'b1;
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait for every expected point, then let the pipeline empty
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [COUNT_BITS-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_count(v);
    endtask

    // one setting of the count: load missing points, then random traffic
    task automatic run_phase(logic [COUNT_BITS-1:0] cnt_val, bit bursty, bit mid_pause);
        int cnt;
        int last_seg;
        int burst_left;
        int s;
        write_count(cnt_val);
        cnt = (cnt_val < MIN_POINTS) ? MIN_POINTS :
              (cnt_val > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt_val);
        last_seg = cnt - 2;
        for (int i = 0; i < cnt; i++)
            if (!loaded[i])
                send_request(write_req(i, rand_coord(), rand_coord(), rand_coord()));
        burst_left = $urandom_range(1, 30);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (mid_pause && n == PHASE_ITEMS / 2)
                drain();
            if (bursty && burst_left == 0)
            begin
                idle_gap($urandom_range(1, 8));
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            if ($urandom_range(0, 9) < 3)
            begin
                // writes mostly land inside the points in use
                s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                                : $urandom_range(0, cnt - 1);
                send_request(write_req(s, rand_coord(), rand_coord(), rand_coord()));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       s = 0;
                    1:       s = last_seg;
                    2:       s = (last_seg < TABLE_DEPTH - 1) ?
                                 $urandom_range(last_seg + 1, TABLE_DEPTH - 1) : last_seg;
                    default: s = $urandom_range(1, last_seg);
                endcase
                send_request(eval_req(s, rand_blend()));
            end
        end
    endtask

    // main sequence
    initial
    begin
        tracker = new();
        foreach (loaded[i])
            loaded[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: count at its reset value, extreme points, every kind of index
        send_request(write_req(0, coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000), '0));
        send_request(write_req(1, coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF),
                               coord_t'(32'h0001_0000)));
        send_request(write_req(2, coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000),
                               coord_t'(32'hFFFF_FFFF)));
        send_request(write_req(3, coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF),
                               coord_t'(32'h7FFF_0000)));
        send_request(eval_req(1, '0));
        send_request(eval_req(1, '1));
        send_request(eval_req(1, 16'h8000));
        send_request(eval_req(2, 16'h8000));
        send_request(eval_req(2, '1));
        send_request(eval_req(0, 16'h4000));
        send_request(eval_req(3, 16'h4000));
        send_request(eval_req(63, '1));
        send_request(write_req(63, coord_t'(32'h5555_AAAA), coord_t'(32'hAAAA_5555),
                               coord_t'(32'h0000_8000)));
        // overwrite then read back to back
        send_request(write_req(1, coord_t'(32'h0002_0000), coord_t'(32'hFFFE_0000),
                               coord_t'(32'h0000_0001)));
        send_request(eval_req(1, 16'h0001));
        send_request(eval_req(2, 16'hC000));

        // random phases over several counts, out of range ones too
        run_phase(7'd64,  1'b1, 1'b0);
        run_phase(7'd5,   1'b0, 1'b0);
        run_phase(7'd2,   1'b1, 1'b1);
        run_phase(7'd100, 1'b1, 1'b0);
        run_phase(7'd37,  1'b1, 1'b0);
        run_phase(7'd127, 1'b0, 1'b0);
        run_phase(7'd4,   1'b1, 1'b0);
        run_phase(7'd64,  1'b1, 1'b1);

        drain();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
